@@ design/twtt_pkg.sv @@
// Shared types and codes of the timing wheel timer table.
`timescale 1ns / 1ps

package twtt_pkg;

	localparam int HANDLE_W = 5;
	localparam int DELAY_W  = 16;
	localparam int TIME_W   = 32;
	localparam int CTX_W    = 32;
	localparam int RES_W    = 16;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_REMOVED = 3'd2;
	localparam logic [2:0] KIND_IGNORED = 3'd3;
	localparam logic [2:0] KIND_EXPIRED = 3'd4;
	localparam logic [2:0] KIND_DONE    = 3'd5;

	typedef struct packed {
		logic [1:0]          action;
		logic [TIME_W-1:0]   now_time;
		logic [DELAY_W-1:0]  delay_seconds;
		logic [CTX_W-1:0]    context_req;
		logic [HANDLE_W-1:0] entry_handle;
	} twtt_cmd_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [HANDLE_W-1:0] handle;
		logic [CTX_W-1:0]    expired_context;
		logic                last;
	} twtt_res_t;

endpackage

@@ design/twtt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module twtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/timing_wheel_timer_table.sv @@
// Top level of the timing wheel timer table: sequencer, link memories and slot divider.
`timescale 1ns / 1ps

// A hashed timing wheel over NUM_ENTRIES timers spread over NUM_BUCKETS buckets, each
// bucket a doubly linked list kept in RAM. A command is transferred when start is high
// and busy is low; busy stays high until the command's last result has been shown. Every
// result appears for exactly one cycle with result_strobe high and cannot be held off, so
// the receiver must take it in that cycle; result.last marks the final one of a command.
// An add runs a 16-step restoring divider that forms delay / resolution and reduces it
// modulo NUM_BUCKETS one quotient bit at a time, then the slot and link states put the
// entry at the head of its bucket. A remove unlinks the entry in the RM_UPD state. A tick
// walks the next bucket: entries that expire or were stale are dropped, pending ones move
// through the link states to the bucket after it; the single read port of the link RAMs
// sets the pace. A pool-full add and an ignored remove answer from idle; the unused action
// code gives no result. No clearing pass runs after reset: bucket heads carry valid bits
// that reset clears. The resolution register may be written only while busy is low.
module timing_wheel_timer_table
	import twtt_pkg::*;
#(
	parameter int NUM_BUCKETS = 64,
	parameter int NUM_ENTRIES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  twtt_cmd_t        cmd,
	input  logic             cfg_wr_en,
	input  logic [RES_W-1:0] cfg_wr_data,
	output logic             result_strobe,
	output twtt_res_t        result
);

	localparam int BW  = $clog2(NUM_BUCKETS);
	localparam int EAW = $clog2(NUM_ENTRIES);
	localparam int EW  = $clog2(NUM_ENTRIES + 1);
	localparam logic [EW-1:0] NIL = EW'(NUM_ENTRIES);
	localparam logic [BW:0]   NB_V = (BW + 1)'(NUM_BUCKETS);
	localparam logic [BW-1:0] LAST_BKT = BW'(NUM_BUCKETS - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_SLOT, ST_LINK_RD, ST_LINK_WR, ST_LINK_FIX,
		ST_T_HEAD, ST_T_CHK, ST_T_EVAL, ST_RM_UPD
	} state_t;

	state_t state_q;

	// Configuration and wheel position.
	logic [RES_W-1:0] resolution_q;
	logic [BW-1:0]    cur_q;
	logic [BW-1:0]    nxt_q;

	// Per-item working registers.
	logic               is_tick_q;
	logic [EW-1:0]      e_q;
	logic [EW-1:0]      n_q;
	logic [EW-1:0]      h_q;
	logic [BW-1:0]      slot_q;
	logic [TIME_W-1:0]  now_q;
	logic               hv_q;
	logic [EW-1:0]      guard_q;

	// Divider registers.
	logic [DELAY_W-1:0] rem_q;
	logic [DELAY_W-1:0] dsh_q;
	logic [3:0]         cnt_q;
	logic [BW-1:0]      mod_q;

	logic [NUM_ENTRIES-1:0] active_q;
	logic [NUM_BUCKETS-1:0] hvalid_q;

	// RAM ports.
	logic            head_we;
	logic [BW-1:0]   head_waddr, head_raddr;
	logic [EW-1:0]   head_wdata, head_rdata;
	logic            next_we, prev_we, bkt_we, dl_we;
	logic [EAW-1:0]  next_waddr, prev_waddr, ent_raddr;
	logic [EW-1:0]   next_wdata, prev_wdata, next_rdata, prev_rdata;
	logic [BW-1:0]   bkt_rdata;
	logic [EAW-1:0]  dl_waddr;
	logic [TIME_W-1:0] dl_wdata, dl_rdata;
	logic [CTX_W-1:0]  ctx_rdata;

	logic            accept;
	logic [BW-1:0]   cur_inc;
	logic [BW-1:0]   cur_inc2;
	logic            free_found;
	logic [EAW-1:0]  free_idx;
	logic [TIME_W:0] dl_sum;
	logic [TIME_W-1:0] dl_sat;
	logic            rm_ok;
	logic [EW-1:0]   link_h;

	// Divider step.
	logic [RES_W-1:0]   divisor;
	logic [DELAY_W:0]   trial;
	logic               qbit;
	logic [DELAY_W-1:0] rem_n;
	logic [BW:0]        mod2;
	logic [BW-1:0]      mod_n;
	logic [BW:0]        slot_sum;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign cur_inc  = (cur_q == LAST_BKT) ? '0 : cur_q + 1'b1;
	assign cur_inc2 = (cur_inc == LAST_BKT) ? '0 : cur_inc + 1'b1;

	// Lowest free entry.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = EAW'(i);
			end
		end
	end

	assign dl_sum = {1'b0, cmd.now_time} + (TIME_W + 1)'(cmd.delay_seconds);
	assign dl_sat = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

	assign rm_ok = (int'(cmd.entry_handle) < NUM_ENTRIES) &&
		active_q[EAW'(cmd.entry_handle)];

	assign link_h = hvalid_q[slot_q] ? head_rdata : NIL;

	assign divisor  = (resolution_q == '0) ? RES_W'(1) : resolution_q;
	assign trial    = {rem_q, dsh_q[DELAY_W-1]};
	assign qbit     = (trial >= {1'b0, divisor});
	assign rem_n    = qbit ? DELAY_W'(trial - {1'b0, divisor}) : trial[DELAY_W-1:0];
	assign mod2     = {mod_q, qbit};
	assign mod_n    = (mod2 >= NB_V) ? BW'(mod2 - NB_V) : mod2[BW-1:0];
	assign slot_sum = {1'b0, cur_q} + {1'b0, mod_q};

	// RAM addressing and writes.
	always_comb begin
		head_raddr = (state_q == ST_IDLE) ? cur_inc : slot_q;
		ent_raddr  = (state_q == ST_IDLE) ? EAW'(cmd.entry_handle) : e_q[EAW-1:0];

		head_we    = 1'b0;
		head_waddr = slot_q;
		head_wdata = e_q;
		next_we    = 1'b0;
		next_waddr = e_q[EAW-1:0];
		next_wdata = link_h;
		prev_we    = 1'b0;
		prev_waddr = e_q[EAW-1:0];
		prev_wdata = NIL;
		bkt_we     = 1'b0;

		dl_we      = accept && (cmd.action == ACT_ADD) && free_found;
		dl_waddr   = free_idx;
		dl_wdata   = dl_sat;

		case (state_q)
			ST_LINK_WR: begin
				head_we = 1'b1;
				next_we = 1'b1;
				prev_we = 1'b1;
				bkt_we  = 1'b1;
			end
			ST_LINK_FIX: begin
				prev_we    = (h_q != NIL);
				prev_waddr = h_q[EAW-1:0];
				prev_wdata = e_q;
			end
			ST_RM_UPD: begin
				if (prev_rdata != NIL) begin
					next_we    = 1'b1;
					next_waddr = prev_rdata[EAW-1:0];
					next_wdata = next_rdata;
				end else begin
					head_we    = 1'b1;
					head_waddr = bkt_rdata;
					head_wdata = next_rdata;
				end
				prev_we    = (next_rdata != NIL);
				prev_waddr = next_rdata[EAW-1:0];
				prev_wdata = prev_rdata;
			end
			default: begin
			end
		endcase
	end

	twtt_ram #(.WIDTH(EW), .DEPTH(NUM_BUCKETS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	twtt_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(ent_raddr), .rdata(next_rdata)
	);

	twtt_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(ent_raddr), .rdata(prev_rdata)
	);

	twtt_ram #(.WIDTH(BW), .DEPTH(NUM_ENTRIES)) u_bkt_ram (
		.clk(clk), .we(bkt_we), .waddr(e_q[EAW-1:0]), .wdata(slot_q),
		.raddr(ent_raddr), .rdata(bkt_rdata)
	);

	twtt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_ENTRIES)) u_dl_ram (
		.clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
		.raddr(ent_raddr), .rdata(dl_rdata)
	);

	twtt_ram #(.WIDTH(CTX_W), .DEPTH(NUM_ENTRIES)) u_ctx_ram (
		.clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(cmd.context_req),
		.raddr(ent_raddr), .rdata(ctx_rdata)
	);

	// Sequencer, control state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			resolution_q  <= RES_W'(1);
			cur_q         <= '0;
			active_q      <= '0;
			hvalid_q      <= '0;
			result_strobe <= 1'b0;
			is_tick_q     <= 1'b0;
			guard_q       <= '0;
		end else begin
			result_strobe <= 1'b0;
			if (cfg_wr_en) begin
				resolution_q <= cfg_wr_data;
			end
			if (head_we) begin
				hvalid_q[head_waddr] <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q <= cmd.now_time;
						case (cmd.action)
							ACT_ADD: begin
								is_tick_q <= 1'b0;
								if (free_found) begin
									active_q[free_idx] <= 1'b1;
									e_q   <= EW'(free_idx);
									rem_q <= '0;
									dsh_q <= cmd.delay_seconds;
									cnt_q <= 4'd15;
									mod_q <= '0;
									state_q <= ST_DIV;
								end else begin
									result_strobe <= 1'b1;
									result <= '{KIND_FULL, '0, '0, 1'b1};
								end
							end
							ACT_REMOVE: begin
								if (rm_ok) begin
									e_q     <= EW'(cmd.entry_handle);
									state_q <= ST_RM_UPD;
								end else begin
									result_strobe <= 1'b1;
									result <= '{KIND_IGNORED, cmd.entry_handle, '0, 1'b1};
								end
							end
							ACT_TICK: begin
								is_tick_q <= 1'b1;
								cur_q     <= cur_inc;
								nxt_q     <= cur_inc2;
								hv_q      <= hvalid_q[cur_inc];
								hvalid_q[cur_inc] <= 1'b0;
								guard_q   <= '0;
								state_q   <= ST_T_HEAD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q <= rem_n;
					dsh_q <= {dsh_q[DELAY_W-2:0], 1'b0};
					mod_q <= mod_n;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					slot_q  <= (slot_sum >= NB_V) ? BW'(slot_sum - NB_V) : slot_sum[BW-1:0];
					state_q <= ST_LINK_RD;
				end
				ST_LINK_RD: begin
					state_q <= ST_LINK_WR;
				end
				ST_LINK_WR: begin
					h_q     <= link_h;
					state_q <= ST_LINK_FIX;
				end
				ST_LINK_FIX: begin
					if (is_tick_q) begin
						e_q     <= n_q;
						state_q <= ST_T_CHK;
					end else begin
						result_strobe <= 1'b1;
						result  <= '{KIND_ADDED, HANDLE_W'(e_q), '0, 1'b1};
						state_q <= ST_IDLE;
					end
				end
				ST_T_HEAD: begin
					e_q     <= hv_q ? head_rdata : NIL;
					state_q <= ST_T_CHK;
				end
				ST_T_CHK: begin
					if ((e_q >= NIL) || (guard_q >= NIL)) begin
						result_strobe <= 1'b1;
						result  <= '{KIND_DONE, '0, '0, 1'b1};
						state_q <= ST_IDLE;
					end else begin
						guard_q <= guard_q + 1'b1;
						state_q <= ST_T_EVAL;
					end
				end
				ST_T_EVAL: begin
					if (active_q[e_q[EAW-1:0]] && (dl_rdata <= now_q)) begin
						active_q[e_q[EAW-1:0]] <= 1'b0;
						result_strobe <= 1'b1;
						result  <= '{KIND_EXPIRED, HANDLE_W'(e_q), ctx_rdata, 1'b0};
						e_q     <= next_rdata;
						state_q <= ST_T_CHK;
					end else if (active_q[e_q[EAW-1:0]]) begin
						n_q     <= next_rdata;
						slot_q  <= nxt_q;
						state_q <= ST_LINK_RD;
					end else begin
						e_q     <= next_rdata;
						state_q <= ST_T_CHK;
					end
				end
				ST_RM_UPD: begin
					active_q[e_q[EAW-1:0]] <= 1'b0;
					result_strobe <= 1'b1;
					result  <= '{KIND_REMOVED, HANDLE_W'(e_q), '0, 1'b1};
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The final result of a command is shown in the cycle the block becomes free again.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |-> !busy)
		else $error("last result shown while still busy");

	// An expiry is never the final result of a tick.
	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.kind == KIND_EXPIRED) |-> !result.last)
		else $error("expired result marked last");

	// The block only becomes busy through a command transfer.
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// Results that are not the last of a command keep the block busy.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> busy)
		else $error("intermediate result while idle");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the timing wheel timer table: stimulus, predictor and checker.
`timescale 1ns / 1ps

module tb_top;
	import twtt_pkg::*;

	localparam int BUCKETS = 64;
	localparam int ENTRIES = 32;
	localparam int NIL     = ENTRIES;
	// Cycles of quiet after the last transfer before the resolution register is touched;
	// a command that gives no result may still be finishing inside the block.
	localparam int CFG_QUIET = 40;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	twtt_cmd_t        cmd;
	logic             cfg_wr_en;
	logic [RES_W-1:0] cfg_wr_data;
	logic             result_strobe;
	twtt_res_t        result;

	timing_wheel_timer_table #(
		.NUM_BUCKETS(BUCKETS),
		.NUM_ENTRIES(ENTRIES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.result_strobe(result_strobe),
		.result       (result)
	);

	// One pending piece of stimulus: either a command or a write of the resolution register.
	typedef struct {
		bit               is_cfg;
		logic [RES_W-1:0] res_value;
		twtt_cmd_t        c;
	} stim_t;

	stim_t     pending_stim[$];
	twtt_res_t expected_results[$];
	bit        failed;

	// Shadow copy of the wheel, updated at every transfer in the order the block sees it.
	logic [RES_W-1:0]    wheel_res;
	logic [5:0]          wheel_cur;
	logic [5:0]          wheel_head [BUCKETS];
	logic [5:0]          wheel_next [ENTRIES];
	logic [5:0]          wheel_prev [ENTRIES];
	logic [5:0]          wheel_bkt  [ENTRIES];
	logic [TIME_W-1:0]   wheel_dl   [ENTRIES];
	logic [CTX_W-1:0]    wheel_ctx  [ENTRIES];
	bit                  wheel_act  [ENTRIES];

	int gap_left;
	int quiet_cycles;

	always #10 clk = ~clk;

	function automatic twtt_res_t make_result(logic [2:0] k, logic [4:0] h,
			logic [CTX_W-1:0] x, logic l);
		twtt_res_t r;
		r.kind            = k;
		r.handle          = h;
		r.expired_context = x;
		r.last            = l;
		return r;
	endfunction

	task automatic push_to_head(int e, int slot);
		int h;
		h = wheel_head[slot];
		wheel_bkt[e]  = 6'(slot);
		wheel_next[e] = 6'(h);
		wheel_prev[e] = 6'(NIL);
		if (h < ENTRIES)
			wheel_prev[h] = 6'(e);
		wheel_head[slot] = 6'(e);
	endtask

	// Works out the results of one transferred command and updates the shadow wheel.
	task automatic wheel_predict(twtt_cmd_t c);
		int               e, n, p, b, slot, res, guard, nxt_slot;
		logic [TIME_W:0]  sum;
		logic [TIME_W-1:0] dl;
		case (c.action)
			ACT_ADD: begin
				e = 0;
				while (e < ENTRIES && wheel_act[e])
					e++;
				if (e >= ENTRIES) begin
					expected_results.push_back(make_result(KIND_FULL, '0, '0, 1'b1));
				end else begin
					// A zero resolution divides as if it were one.
					res = (wheel_res == 0) ? 1 : int'(wheel_res);
					sum = {1'b0, c.now_time} + (TIME_W + 1)'(c.delay_seconds);
					dl  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
					slot = (int'(wheel_cur) + int'(c.delay_seconds) / res) % BUCKETS;
					wheel_dl[e]  = dl;
					wheel_ctx[e] = c.context_req;
					wheel_act[e] = 1;
					push_to_head(e, slot);
					expected_results.push_back(make_result(KIND_ADDED, 5'(e), '0, 1'b1));
				end
			end
			ACT_REMOVE: begin
				e = c.entry_handle;
				if (!wheel_act[e]) begin
					expected_results.push_back(make_result(KIND_IGNORED, 5'(e), '0, 1'b1));
				end else begin
					p = wheel_prev[e];
					n = wheel_next[e];
					b = wheel_bkt[e];
					if (p < ENTRIES)
						wheel_next[p] = 6'(n);
					else
						wheel_head[b] = 6'(n);
					if (n < ENTRIES)
						wheel_prev[n] = 6'(p);
					wheel_next[e] = 6'(NIL);
					wheel_prev[e] = 6'(NIL);
					wheel_act[e]  = 0;
					expected_results.push_back(make_result(KIND_REMOVED, 5'(e), '0, 1'b1));
				end
			end
			ACT_TICK: begin
				wheel_cur = wheel_cur + 6'd1;
				nxt_slot  = (int'(wheel_cur) + 1) % BUCKETS;
				e = wheel_head[wheel_cur];
				wheel_head[wheel_cur] = 6'(NIL);
				guard = 0;
				while (e < ENTRIES && guard < ENTRIES) begin
					n = wheel_next[e];
					guard++;
					if (wheel_act[e] && wheel_dl[e] <= c.now_time) begin
						wheel_act[e]  = 0;
						wheel_next[e] = 6'(NIL);
						wheel_prev[e] = 6'(NIL);
						expected_results.push_back(
							make_result(KIND_EXPIRED, 5'(e), wheel_ctx[e], 1'b0));
					end else if (wheel_act[e]) begin
						push_to_head(e, nxt_slot);
					end
					e = n;
				end
				expected_results.push_back(make_result(KIND_DONE, '0, '0, 1'b1));
			end
			default: begin
				// The unused action code leaves everything as it is.
			end
		endcase
	endtask

	// Driver. A transfer happens at an edge where start was high and busy low; the
	// predictor runs right there, so register writes and commands stay in order.
	always @(posedge clk or negedge arst_n) begin
		bit               accepted;
		logic             n_start, n_wr_en;
		logic [RES_W-1:0] n_wr_data;
		twtt_cmd_t        n_cmd;
		stim_t            s;
		if (!arst_n) begin
			start        <= 1'b0;
			cmd          <= '0;
			cfg_wr_en    <= 1'b0;
			cfg_wr_data  <= '0;
			gap_left     <= 0;
			quiet_cycles <= 0;
		end else begin
			n_start   = start;
			n_cmd     = cmd;
			n_wr_en   = 1'b0;
			n_wr_data = cfg_wr_data;
			if (cfg_wr_en)
				wheel_res = cfg_wr_data;
			accepted = start && !busy;
			if (accepted)
				wheel_predict(cmd);
			quiet_cycles <= accepted ? 0 : quiet_cycles + 1;
			if (!start || accepted) begin
				n_start = 1'b0;
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_stim.size() != 0) begin
					s = pending_stim[0];
					if (s.is_cfg) begin
						// Register writes wait until the block has gone quiet.
						if (!start && !busy && !cfg_wr_en && expected_results.size() == 0
								&& quiet_cycles >= CFG_QUIET) begin
							n_wr_en   = 1'b1;
							n_wr_data = s.res_value;
							void'(pending_stim.pop_front());
						end
					end else begin
						n_start = 1'b1;
						n_cmd   = s.c;
						void'(pending_stim.pop_front());
						// Mostly back to back, sometimes a short pause, rarely a long one.
						case ($urandom_range(0, 19))
							0:          gap_left <= $urandom_range(10, 40);
							1, 2, 3, 4: gap_left <= $urandom_range(1, 3);
							default:    gap_left <= 0;
						endcase
					end
				end
			end
			start       <= n_start;
			cmd         <= n_cmd;
			cfg_wr_en   <= n_wr_en;
			cfg_wr_data <= n_wr_data;
		end
	end

	// Monitor. Every strobed result must match the oldest outstanding expectation.
	always @(posedge clk) begin
		twtt_res_t want;
		if (arst_n && result_strobe) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				failed = 1;
			end else begin
				want = expected_results.pop_front();
				if (result.kind !== want.kind)
					$display("%0t: kind mismatch, expected %0d, actual %0d",
						$time, want.kind, result.kind);
				if (result.handle !== want.handle)
					$display("%0t: handle mismatch, expected %0d, actual %0d",
						$time, want.handle, result.handle);
				if (result.expired_context !== want.expired_context)
					$display("%0t: context mismatch, expected %h, actual %h",
						$time, want.expired_context, result.expired_context);
				if (result.last !== want.last)
					$display("%0t: last mismatch, expected %b, actual %b",
						$time, want.last, result.last);
				if (result !== want)
					failed = 1;
			end
		end
	end

	task automatic queue_cmd(logic [1:0] a, logic [TIME_W-1:0] t, logic [DELAY_W-1:0] d,
			logic [CTX_W-1:0] x, logic [HANDLE_W-1:0] h);
		stim_t s;
		s.is_cfg            = 0;
		s.res_value         = '0;
		s.c.action          = a;
		s.c.now_time        = t;
		s.c.delay_seconds   = d;
		s.c.context_req     = x;
		s.c.entry_handle    = h;
		pending_stim.push_back(s);
	endtask

	task automatic queue_cfg(logic [RES_W-1:0] v);
		stim_t s;
		s.is_cfg    = 1;
		s.res_value = v;
		s.c         = '0;
		pending_stim.push_back(s);
	endtask

	initial begin
		logic [RES_W-1:0]  res_list [5];
		logic [TIME_W-1:0] tnow, t;
		logic [1:0]        a;
		int                res_eff, r, d;

		clk    = 1'b0;
		arst_n = 1'b0;
		failed = 0;
		wheel_res = 1;
		wheel_cur = 0;
		for (int i = 0; i < BUCKETS; i++)
			wheel_head[i] = 6'(NIL);
		for (int i = 0; i < ENTRIES; i++) begin
			wheel_next[i] = 0;
			wheel_prev[i] = 0;
			wheel_bkt[i]  = 0;
			wheel_dl[i]   = 0;
			wheel_ctx[i]  = 0;
			wheel_act[i]  = 0;
		end

		// Directed part, under the reset resolution of one.
		queue_cmd(ACT_ADD, 32'd0, 16'd0, 32'h0000_0000, 5'd0);
		queue_cmd(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31); // saturating deadline
		queue_cmd(ACT_ADD, 32'd100, 16'd1, 32'hA5A5_5A5A, 5'd0);
		queue_cmd(ACT_ADD, 32'd100, 16'd1, 32'h1234_5678, 5'd0);
		queue_cmd(ACT_REMOVE, 32'd0, 16'd0, 32'd0, 5'd1);          // active entry
		queue_cmd(ACT_REMOVE, 32'd0, 16'd0, 32'd0, 5'd1);          // now inactive
		queue_cmd(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
		queue_cmd(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd31); // unused action
		queue_cmd(ACT_TICK, 32'd0, 16'd0, 32'd0, 5'd0);
		queue_cmd(ACT_TICK, 32'd101, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
		queue_cmd(ACT_TICK, 32'd50, 16'd0, 32'd0, 5'd0);
		queue_cmd(ACT_TICK, 32'hFFFF_FFFF, 16'd0, 32'd0, 5'd0);
		// Fill the pool to exhaustion, then the last two adds find it full.
		for (int i = 0; i < ENTRIES + 1; i++)
			queue_cmd(ACT_ADD, 32'd200, i[15:0], $urandom, $urandom);
		queue_cmd(ACT_REMOVE, 32'd0, 16'd0, 32'd0, 5'd7);
		queue_cmd(ACT_ADD, 32'd200, 16'd2, 32'hDEAD_BEEF, 5'd0);
		for (int i = 0; i < 3; i++)
			queue_cmd(ACT_TICK, 32'hFFFF_FFFF, 16'd0, 32'd0, 5'd0);

		// Random part over several resolutions, the extremes among them.
		res_list[0] = 16'd0;
		res_list[1] = 16'd3;
		res_list[2] = 16'hFFFF;
		res_list[3] = 16'd1;
		res_list[4] = $urandom_range(2, 200);
		tnow = 32'd1000;
		for (int p = 0; p < 5; p++) begin
			queue_cfg(res_list[p]);
			res_eff = (res_list[p] == 0) ? 1 : int'(res_list[p]);
			for (int i = 0; i < 34; i++) begin
				r = $urandom_range(0, 99);
				if (r < 40) begin
					d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 3 * res_eff);
					if (d > 65535)
						d = 65535;
					t = ($urandom_range(0, 19) == 0) ? $urandom : tnow;
					queue_cmd(ACT_ADD, t, d[15:0], $urandom, $urandom);
				end else if (r < 60) begin
					queue_cmd(ACT_REMOVE, $urandom, $urandom, $urandom, $urandom);
				end else if (r < 96) begin
					tnow = tnow + $urandom_range(0, 2 * res_eff);
					case ($urandom_range(0, 19))
						0:       t = $urandom;
						1:       t = '1;
						default: t = tnow;
					endcase
					queue_cmd(ACT_TICK, t, $urandom, $urandom, $urandom);
				end else begin
					queue_cmd(2'd3, $urandom, $urandom, $urandom, $urandom);
				end
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every item transferred and every expected result seen.
		do
			@(posedge clk);
		while (pending_stim.size() != 0 || start || busy || expected_results.size() != 0);
		repeat (200) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("timing_wheel_timer_table test passed");
		else
			$display("timing_wheel_timer_table test failed");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("timing_wheel_timer_table test failed");
		$finish;
	end

endmodule
